// ===== rtl/core/i2cblm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cblm_pkg
// Shared types and constants of the bit-level I2C master core.
// ----------------------------------------------------------------------------
package i2cblm_pkg;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int HOLD_W      = 16;
    localparam int BIT_CNT_W   = $clog2(BYTE_W);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(10);

    typedef enum logic [CMD_W-1:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_SEND_BYTE = 3'd2,
        OP_RECV_BYTE = 3'd3,
        OP_SEND_ACK  = 3'd4,
        OP_RECV_ACK  = 3'd5
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } back_state_t;

    // one classified request as it waits in the queue
    typedef struct packed {
        op_t               op;
        logic [BYTE_W-1:0] tx_byte;
        logic              ack_out;
        logic [BYTE_W-1:0] sda_samples;
    } cmd_entry_t;

    // queue side of the queue/back-end link
    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } queue_head_t;

endpackage

// ===== rtl/core/i2cblm_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cblm_front
// Request intake: takes a request, drops unknown command codes and hands
// the rest to the queue through one register stage.
// ----------------------------------------------------------------------------
module i2cblm_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2cblm_pkg::CMD_W-1:0]  s_cmd,
    input  logic [i2cblm_pkg::BYTE_W-1:0] s_tx_byte,
    input  logic                          s_ack_out,
    input  logic [i2cblm_pkg::BYTE_W-1:0] s_sda_samples,
    output logic                          push_valid,
    output i2cblm_pkg::cmd_entry_t        push_entry,
    input  logic                          push_ready
);
    import i2cblm_pkg::*;

    logic       front_valid_reg, front_valid_next;
    cmd_entry_t front_entry_reg, front_entry_next;
    logic       cmd_known;
    logic       load;

    assign cmd_known = (s_cmd <= CMD_W'(OP_RECV_ACK));
    assign s_ready   = !front_valid_reg || push_ready;
    assign load      = s_valid && s_ready && cmd_known;

    always_comb begin
        front_valid_next = front_valid_reg;
        front_entry_next = front_entry_reg;
        if (front_valid_reg && push_ready) begin
            front_valid_next = 1'b0;
        end
        if (load) begin
            front_valid_next             = 1'b1;
            front_entry_next.op          = op_t'(s_cmd);
            front_entry_next.tx_byte     = s_tx_byte;
            front_entry_next.ack_out     = s_ack_out;
            front_entry_next.sda_samples = s_sda_samples;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_valid_reg <= 1'b0;
        end else begin
            front_valid_reg <= front_valid_next;
        end
        front_entry_reg <= front_entry_next;
    end

    assign push_valid = front_valid_reg;
    assign push_entry = front_entry_reg;

endmodule

// ===== rtl/core/i2cblm_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cblm_queue
// Short request queue between the intake and the bus sequencer.
// ----------------------------------------------------------------------------
module i2cblm_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push_valid,
    input  i2cblm_pkg::cmd_entry_t  push_entry,
    output logic                    push_ready,
    output i2cblm_pkg::queue_head_t head,
    input  logic                    pop
);
    import i2cblm_pkg::*;

    cmd_entry_t        entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== rtl/core/i2cblm_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cblm_back
// Bus phase sequencer: steps through the phases of one request, holds each
// phase until its programmed hold has run out and registers the result.
// ----------------------------------------------------------------------------
module i2cblm_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [i2cblm_pkg::HOLD_W-1:0] cfg_wdata,
    input  i2cblm_pkg::queue_head_t       head,
    output logic                          pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_scl_level,
    output logic                          m_sda_level,
    output logic                          m_last_phase,
    output logic [i2cblm_pkg::BYTE_W-1:0] m_rx_byte,
    output logic                          m_ack_in
);
    import i2cblm_pkg::*;

    back_state_t          state_reg, state_next;
    op_t                  op_reg;
    logic [BYTE_W-1:0]    tx_shift_reg;
    logic                 ack_out_reg;
    logic [BYTE_W-1:0]    samples_reg;
    logic [BIT_CNT_W-1:0] bit_reg;
    logic [1:0]           sub_reg;
    logic [HOLD_W-1:0]    hold_cfg_reg;
    logic [HOLD_W-1:0]    hold_cnt_reg;
    logic                 scl_drive_reg, sda_drive_reg;
    logic                 m_valid_reg;
    logic                 m_scl_reg, m_sda_reg, m_last_reg, m_ack_reg;
    logic [BYTE_W-1:0]    m_rx_reg;

    // decoded current phase
    logic                 ph_is_scl, ph_level, ph_last, ph_bit_step;
    logic [1:0]           ph_sub_next;
    logic                 ph_data;
    logic                 fire;
    logic                 scl_new, sda_new;

    always_comb begin
        ph_is_scl   = 1'b0;
        ph_level    = 1'b1;
        ph_last     = 1'b0;
        ph_bit_step = 1'b0;
        ph_sub_next = sub_reg + 2'd1;
        ph_data     = 1'b1;
        case (op_reg)
            OP_START: begin
                // SDA1, SCL1, SDA0, SCL0
                ph_is_scl = sub_reg[0];
                ph_level  = !sub_reg[1];
                ph_last   = (sub_reg == 2'd3);
            end
            OP_STOP: begin
                // SDA0, SCL1, SDA1
                ph_is_scl = (sub_reg == 2'd1);
                ph_level  = (sub_reg != 2'd0);
                ph_last   = (sub_reg == 2'd2);
            end
            default: begin
                // data bit: SDA data, SCL1, SCL0
                if (op_reg == OP_SEND_BYTE) begin
                    ph_data = tx_shift_reg[BYTE_W-1];
                end else if (op_reg == OP_SEND_ACK) begin
                    ph_data = ack_out_reg;
                end
                ph_is_scl = (sub_reg != 2'd0);
                ph_level  = (sub_reg == 2'd0) ? ph_data : (sub_reg == 2'd1);
                if (sub_reg == 2'd2) begin
                    ph_bit_step = 1'b1;
                    if (op_reg == OP_SEND_BYTE || op_reg == OP_RECV_BYTE) begin
                        ph_last = (bit_reg == BIT_CNT_W'(BYTE_W - 1));
                    end else begin
                        ph_last = 1'b1;
                    end
                    // receive byte releases SDA only once, up front
                    ph_sub_next = (op_reg == OP_RECV_BYTE) ? 2'd1 : 2'd0;
                end
            end
        endcase
    end

    assign scl_new = ph_is_scl ? ph_level : scl_drive_reg;
    assign sda_new = ph_is_scl ? sda_drive_reg : ph_level;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (head.valid) begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (fire && ph_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb begin
        pop  = 1'b0;
        fire = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                pop = head.valid;
            end
            ST_RUN: begin
                fire = (hold_cnt_reg == '0) && (!m_valid_reg || m_ready);
            end
            default: begin
                pop  = 1'b0;
                fire = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            hold_cfg_reg  <= HOLD_RESET;
            hold_cnt_reg  <= '0;
            scl_drive_reg <= 1'b1;
            sda_drive_reg <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                hold_cfg_reg <= cfg_wdata;
            end
            if (fire) begin
                hold_cnt_reg  <= (hold_cfg_reg == '0) ? '0 : hold_cfg_reg - 1'b1;
                scl_drive_reg <= scl_new;
                sda_drive_reg <= sda_new;
                m_valid_reg   <= 1'b1;
            end else begin
                if (hold_cnt_reg != '0) begin
                    hold_cnt_reg <= hold_cnt_reg - 1'b1;
                end
                if (m_ready) begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
        if (pop) begin
            op_reg       <= head.entry.op;
            tx_shift_reg <= head.entry.tx_byte;
            ack_out_reg  <= head.entry.ack_out;
            samples_reg  <= head.entry.sda_samples;
            bit_reg      <= '0;
            sub_reg      <= 2'd0;
        end else if (fire) begin
            sub_reg <= ph_sub_next;
            if (ph_bit_step) begin
                bit_reg      <= bit_reg + 1'b1;
                tx_shift_reg <= {tx_shift_reg[BYTE_W-2:0], 1'b0};
            end
        end
        if (fire) begin
            m_scl_reg  <= scl_new;
            m_sda_reg  <= sda_new;
            m_last_reg <= ph_last;
            m_rx_reg   <= (ph_last && op_reg == OP_RECV_BYTE) ? samples_reg : '0;
            m_ack_reg  <= ph_last && (op_reg == OP_RECV_ACK) && samples_reg[BYTE_W-1];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_scl_level  = m_scl_reg;
    assign m_sda_level  = m_sda_reg;
    assign m_last_phase = m_last_reg;
    assign m_rx_byte    = m_rx_reg;
    assign m_ack_in     = m_ack_reg;

    a_last_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ph_last) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after last phase");

    a_scl_low_after: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && ph_last && op_reg != OP_STOP) |=> !scl_drive_reg)
        else $error("SCL not held low at end of request");

    a_data_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_last_reg) |-> (m_rx_reg == '0 && !m_ack_reg))
        else $error("receive data on a non-final phase");

    a_hold_spacing: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && hold_cfg_reg > HOLD_W'(1) && !cfg_we) |=> !fire)
        else $error("phase emitted before hold time elapsed");

endmodule

// ===== rtl/core/i2c_bit_level_master_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core
// Bit-level open-drain I2C master: turns bus commands into timed phases.
// ----------------------------------------------------------------------------
// A request is delivered as a series of phases on the result side:
// start 4 phases, stop 3, send byte 24, receive byte 17, send ack 3,
// receive ack 3. The hold counter in the phase sequencer sets how long
// each phase lasts; a stalled result channel stretches it, and at a hold
// of 1 the sequencer loads each next request in its idle state, between
// the phases of two requests. Requests are taken at one per cycle
// until the intake register and the two-entry queue are full, so the next
// requests wait for ready while the current one is on the bus. Unknown
// command codes are taken and produce no phases. Level 1 on scl/sda means
// the line is released.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [i2cblm_pkg::HOLD_W-1:0] cfg_wdata,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [i2cblm_pkg::CMD_W-1:0]  s_cmd,
    input  logic [i2cblm_pkg::BYTE_W-1:0] s_tx_byte,
    input  logic                          s_ack_out,
    input  logic [i2cblm_pkg::BYTE_W-1:0] s_sda_samples,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_scl_level,
    output logic                          m_sda_level,
    output logic                          m_last_phase,
    output logic [i2cblm_pkg::BYTE_W-1:0] m_rx_byte,
    output logic                          m_ack_in
);
    import i2cblm_pkg::*;

    logic        push_valid, push_ready, pop;
    cmd_entry_t  push_entry;
    queue_head_t head;

    i2cblm_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_tx_byte     (s_tx_byte),
        .s_ack_out     (s_ack_out),
        .s_sda_samples (s_sda_samples),
        .push_valid    (push_valid),
        .push_entry    (push_entry),
        .push_ready    (push_ready)
    );

    i2cblm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .push_ready (push_ready),
        .head       (head),
        .pop        (pop)
    );

    i2cblm_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .head         (head),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_scl_level  (m_scl_level),
        .m_sda_level  (m_sda_level),
        .m_last_phase (m_last_phase),
        .m_rx_byte    (m_rx_byte),
        .m_ack_in     (m_ack_in)
    );

endmodule

// ===== bench/i2c_bit_level_master_core_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core_checker
// Watches both channels of the I2C master core, expands every accepted
// request into its expected bus phases and compares each delivered phase.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_core_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    input  logic                          s_ready,
    input  logic [i2cblm_pkg::CMD_W-1:0]  s_cmd,
    input  logic [i2cblm_pkg::BYTE_W-1:0] s_tx_byte,
    input  logic                          s_ack_out,
    input  logic [i2cblm_pkg::BYTE_W-1:0] s_sda_samples,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic                          m_scl_level,
    input  logic                          m_sda_level,
    input  logic                          m_last_phase,
    input  logic [i2cblm_pkg::BYTE_W-1:0] m_rx_byte,
    input  logic                          m_ack_in,
    output int                            mismatch_count,
    output int                            pending_phases,
    output int                            requests_seen,
    output int                            phases_checked
);
    import i2cblm_pkg::*;

    typedef struct packed {
        logic              scl;
        logic              sda;
        logic              last;
        logic [BYTE_W-1:0] rx_byte;
        logic              ack_in;
    } bus_phase_t;

    localparam logic              SDA_LINE     = 1'b0;
    localparam logic              SCL_LINE     = 1'b1;
    localparam logic [BYTE_W-1:0] MSB_MASK     = 8'h80;
    localparam int                REPORT_LIMIT = 10;

    bus_phase_t  phase_q[$];
    logic        scl_drv;
    logic        sda_drv;

    // one write of one line; the phase carries both drive levels after it
    task automatic drive_line(input logic which, input logic level);
        bus_phase_t ph;
        if (which == SCL_LINE) scl_drv = level;
        else sda_drv = level;
        ph = '0;
        ph.scl = scl_drv;
        ph.sda = sda_drv;
        phase_q.push_back(ph);
    endtask

    task automatic close_request(input logic [BYTE_W-1:0] rx, input logic ack);
        bus_phase_t tail;
        tail = phase_q.pop_back();
        tail.last    = 1'b1;
        tail.rx_byte = rx;
        tail.ack_in  = ack;
        phase_q.push_back(tail);
    endtask

    task automatic expand_request(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] tx,
                                  input logic ack, input logic [BYTE_W-1:0] samples);
        case (op_t'(cmd))
            OP_START: begin
                drive_line(SDA_LINE, 1'b1);
                drive_line(SCL_LINE, 1'b1);
                drive_line(SDA_LINE, 1'b0);
                drive_line(SCL_LINE, 1'b0);
                close_request('0, 1'b0);
            end
            OP_STOP: begin
                drive_line(SDA_LINE, 1'b0);
                drive_line(SCL_LINE, 1'b1);
                drive_line(SDA_LINE, 1'b1);
                close_request('0, 1'b0);
            end
            OP_SEND_BYTE: begin
                for (int i = BYTE_W - 1; i >= 0; i--) begin
                    drive_line(SDA_LINE, tx[i]);
                    drive_line(SCL_LINE, 1'b1);
                    drive_line(SCL_LINE, 1'b0);
                end
                close_request('0, 1'b0);
            end
            OP_RECV_BYTE: begin
                drive_line(SDA_LINE, 1'b1);
                for (int i = 0; i < BYTE_W; i++) begin
                    drive_line(SCL_LINE, 1'b1);
                    drive_line(SCL_LINE, 1'b0);
                end
                close_request(samples, 1'b0);
            end
            OP_SEND_ACK: begin
                drive_line(SDA_LINE, ack);
                drive_line(SCL_LINE, 1'b1);
                drive_line(SCL_LINE, 1'b0);
                close_request('0, 1'b0);
            end
            OP_RECV_ACK: begin
                drive_line(SDA_LINE, 1'b1);
                drive_line(SCL_LINE, 1'b1);
                drive_line(SCL_LINE, 1'b0);
                close_request('0, (samples & MSB_MASK) != '0);
            end
            default: begin
                // spare codes are consumed without touching the bus
            end
        endcase
    endtask

    task automatic check_phase(input bus_phase_t got);
        bus_phase_t want;
        if (phase_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
                $display("ERROR %0t: phase with none pending: scl %0b sda %0b last %0b rx %02h ack %0b",
                         $realtime, got.scl, got.sda, got.last, got.rx_byte, got.ack_in);
        end else begin
            want = phase_q.pop_front();
            phases_checked++;
            if (got.scl !== want.scl || got.sda !== want.sda || got.last !== want.last ||
                got.rx_byte !== want.rx_byte || got.ack_in !== want.ack_in) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("ERROR %0t: phase %0d exp scl %0b sda %0b last %0b rx %02h ack %0b, got scl %0b sda %0b last %0b rx %02h ack %0b",
                             $realtime, phases_checked, want.scl, want.sda, want.last,
                             want.rx_byte, want.ack_in, got.scl, got.sda, got.last,
                             got.rx_byte, got.ack_in);
            end
        end
    endtask

    always @(posedge aclk) begin
        bus_phase_t got;
        if (!aresetn) begin
            phase_q.delete();
            scl_drv        = 1'b1;
            sda_drv        = 1'b1;
            mismatch_count = 0;
            requests_seen  = 0;
            phases_checked = 0;
        end else begin
            // results first: a request taken this edge cannot have produced one yet
            if (m_valid && m_ready) begin
                got.scl     = m_scl_level;
                got.sda     = m_sda_level;
                got.last    = m_last_phase;
                got.rx_byte = m_rx_byte;
                got.ack_in  = m_ack_in;
                check_phase(got);
            end
            if (s_valid && s_ready) begin
                expand_request(s_cmd, s_tx_byte, s_ack_out, s_sda_samples);
                requests_seen++;
            end
        end
        pending_phases = phase_q.size();
    end

endmodule

// ===== bench/i2c_bit_level_master_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_core_tb
// Drives bus command requests into the I2C master core under several hold
// settings and handshake patterns; the checker predicts and compares phases.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_core_tb;
    import i2cblm_pkg::*;

    localparam int                CLK_HALF     = 6;
    localparam int                TIMEOUT_NS   = 48_000_000;
    localparam logic [CMD_W-1:0]  CMD_SPARE_LO = 3'd6;
    localparam logic [CMD_W-1:0]  CMD_SPARE_HI = 3'd7;
    localparam logic [HOLD_W-1:0] HOLD_MIN     = 16'd1;
    localparam logic [HOLD_W-1:0] HOLD_MAX     = 16'hFFFF;
    localparam int                MODE_NONE    = 0;
    localparam int                MODE_TX_IDLE = 1;
    localparam int                MODE_RX_STALL = 2;
    localparam int                MODE_BOTH    = 3;
    localparam int                HEAVY_PCT    = 82;
    localparam int                LIGHT_PCT    = 9;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                cfg_we        = 1'b0;
    logic [HOLD_W-1:0]   cfg_wdata     = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [CMD_W-1:0]    s_cmd         = '0;
    logic [BYTE_W-1:0]   s_tx_byte     = '0;
    logic                s_ack_out     = 1'b0;
    logic [BYTE_W-1:0]   s_sda_samples = '0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic                m_scl_level;
    logic                m_sda_level;
    logic                m_last_phase;
    logic [BYTE_W-1:0]   m_rx_byte;
    logic                m_ack_in;

    int                  mismatch_count;
    int                  pending_phases;
    int                  requests_seen;
    int                  phases_checked;

    int                  idle_mode     = MODE_NONE;
    int                  ready_holdoff = 0;
    int                  req_sent      = 0;
    int                  hold_writes   = 0;
    logic [HOLD_W-1:0]   hold_now      = HOLD_RESET;

    always #(CLK_HALF) aclk = ~aclk;

    i2c_bit_level_master_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_tx_byte     (s_tx_byte),
        .s_ack_out     (s_ack_out),
        .s_sda_samples (s_sda_samples),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_scl_level   (m_scl_level),
        .m_sda_level   (m_sda_level),
        .m_last_phase  (m_last_phase),
        .m_rx_byte     (m_rx_byte),
        .m_ack_in      (m_ack_in)
    );

    i2c_bit_level_master_core_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_tx_byte      (s_tx_byte),
        .s_ack_out      (s_ack_out),
        .s_sda_samples  (s_sda_samples),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_scl_level    (m_scl_level),
        .m_sda_level    (m_sda_level),
        .m_last_phase   (m_last_phase),
        .m_rx_byte      (m_rx_byte),
        .m_ack_in       (m_ack_in),
        .mismatch_count (mismatch_count),
        .pending_phases (pending_phases),
        .requests_seen  (requests_seen),
        .phases_checked (phases_checked)
    );

    // result side: random stalls per mode, plus a counted long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (ready_holdoff > 0) begin
                m_ready <= 1'b0;
                ready_holdoff--;
            end else if (idle_mode == MODE_RX_STALL) begin
                m_ready <= ($urandom_range(99) >= HEAVY_PCT);
            end else if (idle_mode == MODE_BOTH) begin
                m_ready <= ($urandom_range(99) >= LIGHT_PCT);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // entered and left at a falling edge
    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] tx,
                            input logic ack, input logic [BYTE_W-1:0] samples);
        int idle_pct;
        idle_pct = (idle_mode == MODE_TX_IDLE) ? HEAVY_PCT :
                   (idle_mode == MODE_BOTH) ? LIGHT_PCT : 0;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_tx_byte     <= tx;
        s_ack_out     <= ack;
        s_sda_samples <= samples;
        do @(posedge aclk); while (!s_ready);
        req_sent++;
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_phases != 0) @(negedge aclk);
        // last phase is still being held on the bus
        repeat (2 * int'(hold_now) + 64) @(negedge aclk);
    endtask

    task automatic write_hold(input logic [HOLD_W-1:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        hold_now  = value;
        hold_writes++;
    endtask

    task automatic send_noise();
        send_req(CMD_W'($urandom_range(7)), BYTE_W'($urandom), 1'($urandom),
                 BYTE_W'($urandom));
    endtask

    // start, address, ack, one to three data bytes each way, stop
    task automatic run_transfer();
        logic rd;
        int   nbytes;
        rd     = 1'($urandom);
        nbytes = $urandom_range(1, 3);
        send_req(OP_START, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
        send_req(OP_SEND_BYTE, {7'($urandom), rd}, 1'($urandom), BYTE_W'($urandom));
        send_req(OP_RECV_ACK, BYTE_W'($urandom), 1'($urandom),
                 {($urandom_range(9) == 0), 7'($urandom)});
        for (int i = 0; i < nbytes; i++) begin
            if (rd) begin
                send_req(OP_RECV_BYTE, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
                // nack closes a read
                send_req(OP_SEND_ACK, BYTE_W'($urandom), (i == nbytes - 1),
                         BYTE_W'($urandom));
            end else begin
                send_req(OP_SEND_BYTE, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
                send_req(OP_RECV_ACK, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
            end
        end
        send_req(OP_STOP, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));
    endtask

    task automatic run_random(input int mode, input int count);
        int target;
        idle_mode = mode;
        target    = req_sent + count;
        while (req_sent < target) begin
            if ($urandom_range(4) == 0) send_noise();
            else run_transfer();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: every command, byte extremes, ack levels, spare codes
        send_req(OP_START,     8'h00, 1'b0, 8'h00);
        send_req(OP_SEND_BYTE, 8'h00, 1'b0, 8'h00);
        send_req(OP_SEND_BYTE, 8'hFF, 1'b1, 8'hFF);
        send_req(OP_SEND_BYTE, 8'hA5, 1'b0, 8'h5A);
        send_req(OP_RECV_ACK,  8'hFF, 1'b1, 8'h80);
        send_req(OP_RECV_ACK,  8'h00, 1'b0, 8'h7F);
        send_req(OP_RECV_BYTE, 8'hFF, 1'b1, 8'h00);
        send_req(OP_RECV_BYTE, 8'h00, 1'b0, 8'hFF);
        send_req(OP_RECV_BYTE, 8'h3C, 1'b0, 8'h5A);
        send_req(OP_SEND_ACK,  8'hFF, 1'b0, 8'hFF);
        send_req(OP_SEND_ACK,  8'h00, 1'b1, 8'h00);
        send_req(CMD_SPARE_LO, 8'hFF, 1'b1, 8'hFF);
        send_req(OP_STOP,      8'h00, 1'b0, 8'h00);
        send_req(CMD_SPARE_HI, 8'hFF, 1'b1, 8'hFF);
        send_req(OP_STOP,      8'hFF, 1'b1, 8'hFF);
        send_req(OP_START,     8'hFF, 1'b1, 8'hFF);
        send_req(OP_START,     8'h00, 1'b0, 8'h00);
        send_req(CMD_SPARE_HI, 8'h00, 1'b0, 8'h00);
        send_req(OP_STOP,      8'h00, 1'b0, 8'h00);

        // shortest hold; long result hold-off while requests keep coming
        write_hold(HOLD_MIN);
        ready_holdoff = 400;
        repeat (12) send_noise();
        // sender pause until the bus has caught up
        s_valid <= 1'b0;
        do @(negedge aclk); while (pending_phases != 0);
        run_random(MODE_NONE, 50);

        // longest hold on a single short request
        write_hold(HOLD_MAX);
        send_req(OP_STOP, BYTE_W'($urandom), 1'($urandom), BYTE_W'($urandom));

        write_hold(16'd2);
        run_random(MODE_TX_IDLE, 60);
        write_hold(16'd7);
        run_random(MODE_RX_STALL, 60);
        write_hold(HOLD_MIN);
        run_random(MODE_BOTH, 60);

        wait_drained();

        $display("Covered %0d requests and %0d bus phases over %0d hold settings",
                 requests_seen, phases_checked, hold_writes + 1);
        $display("with free-running, sender-idle, receiver-stall and mixed handshakes.");
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("%0d mismatches", mismatch_count);
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("timeout with %0d phases pending", pending_phases);
        $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/i2cblm_pkg.sv
rtl/core/i2cblm_front.sv
rtl/core/i2cblm_queue.sv
rtl/core/i2cblm_back.sv
rtl/core/i2c_bit_level_master_core.sv
bench/i2c_bit_level_master_core_checker.sv
bench/i2c_bit_level_master_core_tb.sv
